// ----- design/vfa_pkg.sv -----
`default_nettype none
package vfa_pkg;

  // Opcodes carried in the action field
  localparam logic [3:0] ACT_ADD   = 4'd0;
  localparam logic [3:0] ACT_ADDS  = 4'd1;
  localparam logic [3:0] ACT_SUB   = 4'd2;
  localparam logic [3:0] ACT_SUBS  = 4'd3;
  localparam logic [3:0] ACT_SCALE = 4'd4;
  localparam logic [3:0] ACT_NEG   = 4'd5;
  localparam logic [3:0] ACT_EQ    = 4'd6;
  localparam logic [3:0] ACT_NE    = 4'd7;
  localparam logic [3:0] ACT_SQMAG = 4'd8;
  localparam logic [3:0] ACT_MAG   = 4'd9;
  localparam logic [3:0] ACT_NORM  = 4'd10;
  localparam logic [3:0] ACT_DOT   = 4'd11;
  localparam logic [3:0] ACT_CROSS = 4'd12;
  localparam logic [3:0] ACT_PROJ  = 4'd13;

  localparam int SQRT_STAGES = 32;  // one root bit per stage
  localparam int DIV_STAGES  = 33;  // one quotient bit per stage

  typedef struct packed {
    logic [3:0]         action;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] az;
    logic signed [31:0] bx;
    logic signed [31:0] by_comp;
    logic signed [31:0] bz;
    logic signed [31:0] scalar_in;
  } in_t;

  typedef struct packed {
    logic signed [31:0] rx;
    logic signed [31:0] ry;
    logic signed [31:0] rz;
    logic signed [31:0] scalar_out;
    logic               compare_flag;
    logic               error_flag;
  } out_t;

  // Leaves the arithmetic front end, travels through the root pipeline
  typedef struct packed {
    logic [3:0]       act;
    logic             err;
    logic             cmp;
    logic [2:0][31:0] r;
    logic [31:0]      sc;
    logic [2:0][31:0] am;    // |a|
    logic [2:0]       an;    // a < 0
    logic             dneg;  // a.b < 0
    logic [63:0]      sq;    // a.a
    logic [2:0][95:0] pn;    // |a_i| * |a.b|
  } mid_t;

  // Travels through the divider
  typedef struct packed {
    logic [3:0]       act;
    logic             err;
    logic             cmp;
    logic [2:0][31:0] r;
    logic [31:0]      sc;
    logic [2:0]       an;
    logic             dneg;
    logic             zero;  // a is the zero vector
  } tail_t;

  // Clamp to the 32-bit signed range; bit 32 flags saturation
  function automatic logic [32:0] sat32(input logic signed [65:0] v);
    logic [32:0] res;
    if (v > 66'sh7FFF_FFFF) begin
      res = {1'b1, 32'h7FFF_FFFF};
    end else if (v < -66'sh8000_0000) begin
      res = {1'b1, 32'h8000_0000};
    end else begin
      res = {1'b0, v[31:0]};
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ----- design/vfa_arith.sv -----
`default_nettype none
module vfa_arith #(
  parameter int FRAC_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          src_valid,
  input  vfa_pkg::in_t  src,
  output logic          dst_valid,
  output vfa_pkg::mid_t dst
);
  import vfa_pkg::*;

  function automatic logic [63:0] smul(input logic signed [31:0] x, input logic signed [31:0] y);
    logic signed [63:0] p;
    p = x * y;
    return p;
  endfunction

  function automatic logic [63:0] umul(input logic [31:0] x, input logic [31:0] y);
    logic [63:0] p;
    p = x * y;
    return p;
  endfunction

  // stage 1: products, element-wise ops, compare
  logic             s1_valid;
  logic [3:0]       s1_act;
  logic             s1_err, s1_cmp;
  logic [2:0][31:0] s1_r, s1_a;
  logic [5:0][63:0] s1_p;

  logic [2:0][31:0] a_w, b_w;
  logic [2:0][31:0] r1_next;
  logic [5:0][63:0] p_next;
  logic             err1_next, cmp1_next;

  assign a_w = {src.az, src.ay, src.ax};
  assign b_w = {src.bz, src.by_comp, src.bx};

  always_comb begin
    logic        is_cross, is_scale, simple, use_b;
    logic [31:0] l0, r0, l1, r1, opnd;
    logic signed [32:0] t;
    logic [32:0] c;
    int j, k;
    is_cross  = src.action == ACT_CROSS;
    is_scale  = src.action == ACT_SCALE;
    simple    = src.action == ACT_ADD || src.action == ACT_ADDS || src.action == ACT_SUB ||
                src.action == ACT_SUBS || src.action == ACT_NEG;
    use_b     = src.action == ACT_ADD || src.action == ACT_SUB;
    err1_next = src.action > ACT_PROJ;
    cmp1_next = 1'b0;
    if (src.action == ACT_EQ) cmp1_next = a_w == b_w;
    if (src.action == ACT_NE) cmp1_next = a_w != b_w;
    for (int l = 0; l < 3; l++) begin
      j = (l + 1) % 3;
      k = (l + 2) % 3;
      if (is_cross) begin
        l0 = a_w[j]; r0 = b_w[k]; l1 = a_w[k]; r1 = b_w[j];
      end else begin
        l0 = a_w[l]; r0 = is_scale ? src.scalar_in : a_w[l]; l1 = a_w[l]; r1 = b_w[l];
      end
      p_next[l]     = smul(l0, r0);
      p_next[l + 3] = smul(l1, r1);
      opnd = use_b ? b_w[l] : src.scalar_in;
      case (src.action)
        ACT_ADD, ACT_ADDS: t = $signed({a_w[l][31], a_w[l]}) + $signed({opnd[31], opnd});
        ACT_SUB, ACT_SUBS: t = $signed({a_w[l][31], a_w[l]}) - $signed({opnd[31], opnd});
        ACT_NEG:           t = -$signed({a_w[l][31], a_w[l]});
        default:           t = '0;
      endcase
      c = sat32(66'(t));
      r1_next[l] = simple ? c[31:0] : '0;
      err1_next  = err1_next | (simple & c[32]);
    end
  end

  // stage 2: sums of products
  logic             s2_valid;
  logic [3:0]       s2_act;
  logic             s2_err, s2_cmp;
  logic [2:0][31:0] s2_r, s2_am;
  logic [2:0]       s2_an;
  logic [2:0][65:0] s2_v;
  logic [65:0]      s2_vs, s2_dot;
  logic [63:0]      s2_sq;

  logic [2:0][65:0] v_next;
  logic [65:0]      dot_next, vs_next;
  logic [63:0]      sq_next;
  logic [2:0][31:0] am_next;
  logic [2:0]       an_next;

  always_comb begin
    sq_next  = s1_p[0] + s1_p[1] + s1_p[2];
    dot_next = 66'($signed(s1_p[3])) + 66'($signed(s1_p[4])) + 66'($signed(s1_p[5]));
    vs_next  = (s1_act == ACT_SQMAG) ? {2'b00, sq_next} : dot_next;
    for (int l = 0; l < 3; l++) begin
      v_next[l]  = (s1_act == ACT_CROSS) ?
                   66'($signed(s1_p[l])) - 66'($signed(s1_p[l + 3])) : 66'($signed(s1_p[l]));
      an_next[l] = s1_a[l][31];
      am_next[l] = s1_a[l][31] ? 32'(-s1_a[l]) : s1_a[l];
    end
  end

  // stage 3: floor, saturate, |a.b|
  mid_t        s3;
  logic        s3_valid;
  logic [63:0] s3_dm;
  mid_t        s3_next;
  logic [63:0] dm_next;

  always_comb begin
    logic        use_v, use_s;
    logic [32:0] c;
    use_v   = s2_act == ACT_SCALE || s2_act == ACT_CROSS;
    use_s   = s2_act == ACT_SQMAG || s2_act == ACT_DOT;
    s3_next = '0;
    s3_next.act = s2_act;
    s3_next.cmp = s2_cmp;
    s3_next.err = s2_err;
    s3_next.am  = s2_am;
    s3_next.an  = s2_an;
    s3_next.sq  = s2_sq;
    s3_next.dneg = s2_dot[65];
    dm_next = s2_dot[65] ? 64'(-s2_dot) : s2_dot[63:0];
    for (int l = 0; l < 3; l++) begin
      c = sat32($signed(s2_v[l]) >>> FRAC_BITS);
      s3_next.r[l] = use_v ? c[31:0] : s2_r[l];
      s3_next.err  = s3_next.err | (use_v & c[32]);
    end
    c = sat32($signed(s2_vs) >>> FRAC_BITS);
    s3_next.sc  = use_s ? c[31:0] : '0;
    s3_next.err = s3_next.err | (use_s & c[32]);
  end

  // stage 4: partial products of |a_i| * |a.b|
  mid_t             s4;
  logic             s4_valid;
  logic [2:0][63:0] s4_pp0, s4_pp1;
  logic [2:0][63:0] pp0_next, pp1_next;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      pp0_next[l] = umul(s3.am[l], s3_dm[31:0]);
      pp1_next[l] = umul(s3.am[l], s3_dm[63:32]);
    end
  end

  // stage 5: combine into 96-bit numerators
  mid_t dst_next;
  always_comb begin
    dst_next = s4;
    for (int l = 0; l < 3; l++) begin
      dst_next.pn[l] = 96'(s4_pp0[l]) + (96'(s4_pp1[l]) << 32);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      dst_valid <= 1'b0;
    end else if (en) begin
      s1_valid  <= src_valid;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      s4_valid  <= s3_valid;
      dst_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_act <= src.action;
      s1_err <= err1_next;
      s1_cmp <= cmp1_next;
      s1_r   <= r1_next;
      s1_a   <= a_w;
      s1_p   <= p_next;
      s2_act <= s1_act;
      s2_err <= s1_err;
      s2_cmp <= s1_cmp;
      s2_r   <= s1_r;
      s2_am  <= am_next;
      s2_an  <= an_next;
      s2_v   <= v_next;
      s2_vs  <= vs_next;
      s2_dot <= dot_next;
      s2_sq  <= sq_next;
      s3     <= s3_next;
      s3_dm  <= dm_next;
      s4     <= s3;
      s4_pp0 <= pp0_next;
      s4_pp1 <= pp1_next;
      dst    <= dst_next;
    end
  end

endmodule
`default_nettype wire

// ----- design/vfa_sqrt.sv -----
`default_nettype none
module vfa_sqrt (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          src_valid,
  input  vfa_pkg::mid_t src,
  output logic          dst_valid,
  output vfa_pkg::mid_t dst,
  output logic [31:0]   root
);
  import vfa_pkg::*;

  localparam int N = SQRT_STAGES;

  // try root bit b: keeps rem = n - root^2
  function automatic logic [95:0] sq_step(input logic [63:0] rem, input logic [31:0] rt,
                                          input int b);
    logic [65:0] trial;
    logic        go;
    trial = (66'(rt) << (b + 1)) + (66'd1 << (2 * b));
    go    = {2'b00, rem} >= trial;
    return {go ? rem - trial[63:0] : rem, rt | (32'(go) << b)};
  endfunction

  logic [N-1:0] vq;
  logic [63:0]  remq [N];
  logic [31:0]  rootq [N];
  mid_t         mq [N];
  logic [63:0]  rem_next [N];
  logic [31:0]  root_next [N];

  always_comb begin
    {rem_next[0], root_next[0]} = sq_step(src.sq, '0, N - 1);
    for (int s = 1; s < N; s++) begin
      {rem_next[s], root_next[s]} = sq_step(remq[s-1], rootq[s-1], N - 1 - s);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vq <= '0;
    end else if (en) begin
      vq <= {vq[N-2:0], src_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mq[0] <= src;
      for (int s = 0; s < N; s++) begin
        remq[s]  <= rem_next[s];
        rootq[s] <= root_next[s];
      end
      for (int s = 1; s < N; s++) begin
        mq[s] <= mq[s-1];
      end
    end
  end

  assign dst_valid = vq[N-1];
  assign dst       = mq[N-1];
  assign root      = rootq[N-1];

endmodule
`default_nettype wire

// ----- design/vfa_div.sv -----
`default_nettype none
module vfa_div (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             src_valid,
  input  logic [2:0][95:0] num,
  input  logic [63:0]      den,
  input  vfa_pkg::tail_t   src,
  output logic             dst_valid,
  output vfa_pkg::tail_t   dst,
  output logic [2:0][32:0] quo,
  output logic [2:0]       ovf
);
  import vfa_pkg::*;

  localparam int N = DIV_STAGES;

  // restoring step for quotient bit k
  function automatic logic [129:0] dv_step(input logic [96:0] rem, input logic [32:0] q,
                                           input logic [63:0] d, input int k);
    logic [96:0] dsh;
    logic        go;
    dsh = 97'(d) << k;
    go  = rem >= dsh;
    return {go ? rem - dsh : rem, q | (33'(go) << k)};
  endfunction

  logic [N-1:0]     vq;
  logic [2:0][96:0] remq [N];
  logic [2:0][32:0] qq [N];
  logic [2:0]       ovq [N];
  logic [63:0]      dq [N];
  tail_t            tq [N];
  logic [2:0][96:0] rem_next [N];
  logic [2:0][32:0] q_next [N];
  logic [2:0]       ov_next;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      ov_next[l] = 97'(num[l]) >= (97'(den) << N);
      {rem_next[0][l], q_next[0][l]} = dv_step(97'(num[l]), '0, den, N - 1);
      for (int s = 1; s < N; s++) begin
        {rem_next[s][l], q_next[s][l]} = dv_step(remq[s-1][l], qq[s-1][l], dq[s-1], N - 1 - s);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vq <= '0;
    end else if (en) begin
      vq <= {vq[N-2:0], src_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ovq[0] <= ov_next;
      dq[0]  <= den;
      tq[0]  <= src;
      for (int s = 0; s < N; s++) begin
        remq[s] <= rem_next[s];
        qq[s]   <= q_next[s];
      end
      for (int s = 1; s < N; s++) begin
        ovq[s] <= ovq[s-1];
        dq[s]  <= dq[s-1];
        tq[s]  <= tq[s-1];
      end
    end
  end

  assign dst_valid = vq[N-1];
  assign dst       = tq[N-1];
  assign quo       = qq[N-1];
  assign ovf       = ovq[N-1];

endmodule
`default_nettype wire

// ----- design/vector3_fixed_point_alu_core.sv -----
`default_nettype none
// Three-component Q16.16 vector ALU, fully pipelined.
// A request passes 5 arithmetic stages, 32 square-root stages, 33 divider
// stages and 1 output register on its way to result_valid.
// Throughput: one request per cycle unless req_stall; bit-serial divider sets depth.
// Reset (rst, synchronous) clears all valid bits, including the output and skid
// valid flags; data registers are not reset.
module vector3_fixed_point_alu_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  vfa_pkg::in_t  req,
  input  logic          req_valid,
  output logic          req_stall,
  output vfa_pkg::out_t result,
  output logic          result_valid,
  input  logic          result_stall
);
  import vfa_pkg::*;

  // Whole pipeline moves together; it freezes only when the skid entry holds
  // a result, so the input stall comes straight from a register.
  logic  en;
  out_t  skid;
  logic  skid_valid;

  assign en        = !skid_valid;
  assign req_stall = skid_valid;

  // Front end: products, sums, floor/saturate, |a_i|*|a.b| numerators
  logic ar_valid;
  mid_t ar;

  vfa_arith #(.FRAC_BITS(FRAC_BITS)) u_arith (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .src_valid (req_valid & ~req_stall),
    .src       (req),
    .dst_valid (ar_valid),
    .dst       (ar)
  );

  // Integer square root of a.a (magnitude, and normalize divisor)
  logic        sr_valid;
  mid_t        sr;
  logic [31:0] root;

  vfa_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .src_valid (ar_valid),
    .src       (ar),
    .dst_valid (sr_valid),
    .dst       (sr),
    .root      (root)
  );

  // Divider operands:
  //   normalize: |a_i| << FRAC_BITS  over  sqrt(a.a)
  //   project:   |a_i| * |a.b|       over  a.a
  // A zero vector a is flagged here; its quotients are ignored.
  logic             is_norm, is_proj;
  logic [32:0]      mag_c;
  logic [2:0][95:0] dv_num;
  logic [63:0]      dv_den;
  tail_t            dv_tail;

  always_comb begin
    is_norm = sr.act == ACT_NORM;
    is_proj = sr.act == ACT_PROJ;
    mag_c   = sat32($signed({34'd0, root}));
    dv_den  = is_norm ? {32'd0, root} : sr.sq;
    for (int l = 0; l < 3; l++) begin
      dv_num[l] = is_norm ? (96'(sr.am[l]) << FRAC_BITS) : sr.pn[l];
    end
    dv_tail.act  = sr.act;
    dv_tail.cmp  = sr.cmp;
    dv_tail.r    = sr.r;
    dv_tail.an   = sr.an;
    dv_tail.dneg = sr.dneg;
    dv_tail.zero = sr.sq == '0;
    dv_tail.sc   = (sr.act == ACT_MAG) ? mag_c[31:0] : sr.sc;
    dv_tail.err  = sr.err | ((sr.act == ACT_MAG) & mag_c[32]) |
                   ((is_norm | is_proj) & dv_tail.zero);
  end

  logic             dv_valid;
  tail_t            dv;
  logic [2:0][32:0] quo;
  logic [2:0]       ovf;

  vfa_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .src_valid (sr_valid),
    .num       (dv_num),
    .den       (dv_den),
    .src       (dv_tail),
    .dst_valid (dv_valid),
    .dst       (dv),
    .quo       (quo),
    .ovf       (ovf)
  );

  // sign-magnitude quotient to 32-bit two's complement, bit 32 = saturated
  function automatic logic [32:0] clamp_q(input logic neg, input logic [32:0] q,
                                          input logic big);
    logic [32:0] res;
    if (!neg) begin
      res = (big || q > 33'h0_7FFF_FFFF) ? {1'b1, 32'h7FFF_FFFF} : {1'b0, q[31:0]};
    end else begin
      res = (big || q > 33'h0_8000_0000) ? {1'b1, 32'h8000_0000} : {1'b0, 32'(-q[31:0])};
    end
    return res;
  endfunction

  // Final assembly of the result fields
  out_t fin;
  always_comb begin
    logic [2:0][31:0] r;
    logic             err, div_op, neg;
    logic [32:0]      c;
    r      = dv.r;
    err    = dv.err;
    div_op = (dv.act == ACT_NORM || dv.act == ACT_PROJ) && !dv.zero;
    for (int l = 0; l < 3; l++) begin
      neg = dv.an[l] ^ ((dv.act == ACT_PROJ) & dv.dneg);
      c   = clamp_q(neg, quo[l], ovf[l]);
      if (div_op) begin
        r[l] = c[31:0];
        err  = err | c[32];
      end
    end
    fin.rx           = r[0];
    fin.ry           = r[1];
    fin.rz           = r[2];
    fin.scalar_out   = dv.sc;
    fin.compare_flag = dv.cmp;
    fin.error_flag   = err;
  end

  // Output register plus one skid entry. A result arriving while the output
  // is stalled parks in the skid entry, which then holds the pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (result_valid && !result_stall) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        result_valid <= dv_valid;
      end
    end else if (result_valid) begin
      if (dv_valid && !skid_valid) begin
        skid_valid <= 1'b1;
      end
    end else begin
      result_valid <= dv_valid && en;
    end
  end

  always_ff @(posedge clk) begin
    if (result_valid && !result_stall) begin
      result <= skid_valid ? skid : fin;
    end else if (!result_valid) begin
      result <= fin;
    end else if (!skid_valid) begin
      skid <= fin;
    end
  end

endmodule
`default_nettype wire

// ----- dv/tb_vector3_fixed_point_alu_core.sv -----
module tb_vector3_fixed_point_alu_core;
  import vfa_pkg::*;

  localparam int FRAC = 16;
  // Cycles without any accepted request or result before the run is abandoned.
  // The pipe is 71 deep and the random gaps are short, so this is far beyond
  // the slowest correct run.
  localparam int STALL_LIMIT = 4000;

  localparam logic signed [31:0] MAXV = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] MINV = 32'sh8000_0000;
  localparam logic signed [31:0] ONE  = 32'sh0001_0000;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  in_t   req = '0;
  logic  req_valid = 1'b0;
  logic  req_stall;
  out_t  result;
  logic  result_valid;
  logic  result_stall = 1'b0;

  out_t  expected_results[$];
  int    fail_count = 0;
  int    quiet_cycles = 0;
  bit    no_idle = 1'b0;

  vector3_fixed_point_alu_core #(.FRAC_BITS(FRAC)) uut (
    .clk(clk), .rst(rst), .req(req), .req_valid(req_valid), .req_stall(req_stall),
    .result(result), .result_valid(result_valid), .result_stall(result_stall)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Clamp to 32-bit signed; bit 32 marks saturation.
  function automatic logic [32:0] clamp32(input logic signed [130:0] v);
    if (v > 131'sd2147483647) begin
      return {1'b1, 32'h7FFF_FFFF};
    end else if (v < -131'sd2147483648) begin
      return {1'b1, 32'h8000_0000};
    end
    return {1'b0, v[31:0]};
  endfunction

  // Sign and magnitude to a clamped 32-bit value.
  function automatic logic [32:0] clamp_sm(input bit neg, input logic [129:0] q);
    logic signed [130:0] v;
    v = $signed({1'b0, q});
    if (neg) begin
      v = -v;
    end
    return clamp32(v);
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] n);
    logic [63:0] root;
    logic [63:0] bitv;
    root = '0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic out_t alu_predict(input in_t x);
    out_t o;
    logic signed [129:0] a[3];
    logic signed [129:0] b[3];
    logic signed [129:0] s;
    logic signed [129:0] acc;
    logic [129:0] am[3];
    logic [129:0] sq;
    logic [129:0] dm;
    logic [129:0] m;
    logic [32:0] c[3];
    bit dneg;
    o = '0;
    a[0] = $signed(x.ax); a[1] = $signed(x.ay); a[2] = $signed(x.az);
    b[0] = $signed(x.bx); b[1] = $signed(x.by_comp); b[2] = $signed(x.bz);
    s = $signed(x.scalar_in);
    for (int i = 0; i < 3; i++) begin
      am[i] = (a[i] < 0) ? -a[i] : a[i];
      c[i] = '0;
    end
    sq = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
    acc = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
    dneg = acc < 0;
    dm = dneg ? -acc : acc;
    case (x.action)
      ACT_ADD:   for (int i = 0; i < 3; i++) c[i] = clamp32(a[i] + b[i]);
      ACT_ADDS:  for (int i = 0; i < 3; i++) c[i] = clamp32(a[i] + s);
      ACT_SUB:   for (int i = 0; i < 3; i++) c[i] = clamp32(a[i] - b[i]);
      ACT_SUBS:  for (int i = 0; i < 3; i++) c[i] = clamp32(a[i] - s);
      ACT_SCALE: for (int i = 0; i < 3; i++) c[i] = clamp32((a[i] * s) >>> FRAC);
      ACT_NEG:   for (int i = 0; i < 3; i++) c[i] = clamp32(-a[i]);
      ACT_EQ:    o.compare_flag = (a[0] == b[0]) && (a[1] == b[1]) && (a[2] == b[2]);
      ACT_NE:    o.compare_flag = (a[0] != b[0]) || (a[1] != b[1]) || (a[2] != b[2]);
      ACT_SQMAG: begin
        c[0] = clamp32($signed({1'b0, sq}) >>> FRAC);
        o.scalar_out = c[0][31:0];
        o.error_flag = c[0][32];
        c[0] = '0;
      end
      ACT_MAG: begin
        c[0] = clamp_sm(1'b0, {66'd0, int_sqrt(sq[63:0])});
        o.scalar_out = c[0][31:0];
        o.error_flag = c[0][32];
        c[0] = '0;
      end
      ACT_NORM: begin
        if (sq == 0) begin
          o.error_flag = 1'b1;
        end else begin
          m = {66'd0, int_sqrt(sq[63:0])};
          for (int i = 0; i < 3; i++) c[i] = clamp_sm(a[i] < 0, (am[i] << FRAC) / m);
        end
      end
      ACT_DOT: begin
        c[0] = clamp32(acc >>> FRAC);
        o.scalar_out = c[0][31:0];
        o.error_flag = c[0][32];
        c[0] = '0;
      end
      ACT_CROSS: begin
        for (int i = 0; i < 3; i++) begin
          c[i] = clamp32((a[(i + 1) % 3] * b[(i + 2) % 3] - a[(i + 2) % 3] * b[(i + 1) % 3])
                         >>> FRAC);
        end
      end
      ACT_PROJ: begin
        if (sq == 0) begin
          o.error_flag = 1'b1;
        end else begin
          for (int i = 0; i < 3; i++) c[i] = clamp_sm((a[i] < 0) != dneg, am[i] * dm / sq);
        end
      end
      default: o.error_flag = 1'b1;  // unused opcodes
    endcase
    o.rx = c[0][31:0];
    o.ry = c[1][31:0];
    o.rz = c[2][31:0];
    o.error_flag = o.error_flag | c[0][32] | c[1][32] | c[2][32];
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver: changes at the falling edge, acceptance seen at the rising
  // ---------------------------------------------------------------------------
  task automatic send_req(input in_t x);
    while (!no_idle && $urandom_range(99) < 29) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req <= x;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    expected_results.push_back(alu_predict(x));
    @(negedge clk);
  endtask

  function automatic in_t mk(input logic [3:0] act,
                             input logic [31:0] ax, input logic [31:0] ay,
                             input logic [31:0] az, input logic [31:0] bx,
                             input logic [31:0] by, input logic [31:0] bz,
                             input logic [31:0] s);
    in_t x;
    x.action = act;
    x.ax = ax; x.ay = ay; x.az = az;
    x.bx = bx; x.by_comp = by; x.bz = bz;
    x.scalar_in = s;
    return x;
  endfunction

  // Mix of extremes, small fixed-point numbers and full-range noise.
  function automatic logic [31:0] rand_comp();
    case ($urandom_range(5))
      0: return $urandom_range(1) ? MAXV : MINV;
      1: return $urandom_range(2) == 0 ? 32'd0 : ($urandom_range(1) ? ONE : -ONE);
      2: return $signed($urandom_range(32'h000F_FFFF)) - 32'sh0008_0000;
      3: return $signed($urandom_range(32'h00FF_FFFF)) - 32'sh0080_0000;
      default: return $urandom;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_directed();
    send_req(mk(ACT_ADD, MAXV, MINV, ONE, MAXV, MINV, -ONE, 0));     // both saturations
    send_req(mk(ACT_ADDS, MAXV, MINV, 0, 0, 0, 0, MINV));
    send_req(mk(ACT_SUB, MINV, MAXV, 0, MAXV, MINV, 0, 0));
    send_req(mk(ACT_SUBS, MINV, MAXV, ONE, 0, 0, 0, MAXV));
    send_req(mk(ACT_SCALE, MINV, MAXV, -1, 0, 0, 0, MINV));        // overflow and floor
    send_req(mk(ACT_SCALE, 3 * ONE, -ONE / 2, 1, 0, 0, 0, ONE / 2));
    send_req(mk(ACT_NEG, MINV, MAXV, 0, 0, 0, 0, 0));              // -min saturates
    send_req(mk(ACT_EQ, ONE, 2, 3, ONE, 2, 3, 0));
    send_req(mk(ACT_EQ, ONE, 2, 3, ONE, 2, 4, 0));
    send_req(mk(ACT_NE, ONE, 2, 3, ONE, 2, 3, 0));
    send_req(mk(ACT_NE, ONE, 2, 3, 0, 2, 3, 0));                   // one component differs
    send_req(mk(ACT_SQMAG, MINV, MINV, MINV, 0, 0, 0, 0));
    send_req(mk(ACT_SQMAG, 3 * ONE, 4 * ONE, 0, 0, 0, 0, 0));
    send_req(mk(ACT_MAG, MINV, MINV, MINV, 0, 0, 0, 0));
    send_req(mk(ACT_MAG, 3 * ONE, -4 * ONE, 0, 0, 0, 0, 0));
    send_req(mk(ACT_NORM, 0, 0, 0, 1, 2, 3, 0));                   // zero vector
    send_req(mk(ACT_NORM, -3 * ONE, 4 * ONE, 1, 0, 0, 0, 0));
    send_req(mk(ACT_NORM, 1, 0, 0, 0, 0, 0, 0));
    send_req(mk(ACT_DOT, MINV, MINV, MINV, MINV, MINV, MINV, 0));
    send_req(mk(ACT_DOT, MAXV, MINV, 5, MINV, MAXV, -7, 0));
    send_req(mk(ACT_CROSS, ONE, 0, 0, 0, ONE, 0, 0));
    send_req(mk(ACT_CROSS, MINV, MAXV, MINV, MAXV, MINV, MAXV, 0));
    send_req(mk(ACT_PROJ, 0, 0, 0, ONE, ONE, ONE, 0));             // zero vector
    send_req(mk(ACT_PROJ, 1, 0, 0, MAXV, MAXV, MAXV, 0));          // huge quotient
    send_req(mk(4'd14, ONE, ONE, ONE, ONE, ONE, ONE, ONE));
    send_req(mk(4'd15, MAXV, MINV, 0, 0, 0, 0, -1));
  endtask

  task automatic test_random_ops(input int count);
    in_t x;
    for (int n = 0; n < count; n++) begin
      x.action = ($urandom_range(19) == 0) ? 4'(14 + $urandom_range(1))
                                           : 4'($urandom_range(13));
      x.ax = rand_comp(); x.ay = rand_comp(); x.az = rand_comp();
      x.bx = rand_comp(); x.by_comp = rand_comp(); x.bz = rand_comp();
      x.scalar_in = rand_comp();
      // comparisons need near-equal operands to be interesting
      if ((x.action == ACT_EQ || x.action == ACT_NE) && $urandom_range(1)) begin
        x.bx = x.ax; x.by_comp = x.ay; x.bz = x.az;
        case ($urandom_range(3))
          0: x.bx = x.bx ^ (32'd1 << $urandom_range(31));
          1: x.by_comp = x.by_comp ^ (32'd1 << $urandom_range(31));
          2: x.bz = x.bz ^ (32'd1 << $urandom_range(31));
          default: ;
        endcase
      end
      if ((x.action == ACT_NORM || x.action == ACT_PROJ) && $urandom_range(9) == 0) begin
        x.ax = 0; x.ay = 0; x.az = 0;
      end
      send_req(x);
    end
  endtask

  task automatic test_back_to_back(input int count);
    no_idle = 1'b1;
    test_random_ops(count);
    no_idle = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stall, compare, watchdog
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    result_stall <= (!no_idle && $urandom_range(99) < 29);
  end

  always @(posedge clk) begin
    out_t exp_r;
    if (!rst) begin
      if ((req_valid && !req_stall) || (result_valid && !result_stall)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("** vector3_fixed_point_alu_core: FAILED **");
        $finish;
      end
      if (result_valid && !result_stall) begin
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding");
          fail_count = fail_count + 1;
        end else begin
          exp_r = expected_results.pop_front();
          if (result.rx !== exp_r.rx) begin
            $error("rx expected %h actual %h", exp_r.rx, result.rx);
            fail_count = fail_count + 1;
          end
          if (result.ry !== exp_r.ry) begin
            $error("ry expected %h actual %h", exp_r.ry, result.ry);
            fail_count = fail_count + 1;
          end
          if (result.rz !== exp_r.rz) begin
            $error("rz expected %h actual %h", exp_r.rz, result.rz);
            fail_count = fail_count + 1;
          end
          if (result.scalar_out !== exp_r.scalar_out) begin
            $error("scalar_out expected %h actual %h", exp_r.scalar_out, result.scalar_out);
            fail_count = fail_count + 1;
          end
          if (result.compare_flag !== exp_r.compare_flag) begin
            $error("compare_flag expected %b actual %b",
                   exp_r.compare_flag, result.compare_flag);
            fail_count = fail_count + 1;
          end
          if (result.error_flag !== exp_r.error_flag) begin
            $error("error_flag expected %b actual %b", exp_r.error_flag, result.error_flag);
            fail_count = fail_count + 1;
          end
        end
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_ops(500);
    test_back_to_back(150);
    test_random_ops(350);
    req_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("** vector3_fixed_point_alu_core: PASSED **");
    end else begin
      $display("** vector3_fixed_point_alu_core: FAILED **");
    end
    $finish;
  end

endmodule

// ----- vector3_fixed_point_alu_core.f -----
design/vfa_pkg.sv
design/vfa_arith.sv
design/vfa_sqrt.sv
design/vfa_div.sv
design/vector3_fixed_point_alu_core.sv
dv/tb_vector3_fixed_point_alu_core.sv
